### hw/rtl/spdif_pkg.sv
// shared types and constants for the biphase-mark frame encoder
package spdif_pkg;

   localparam logic [7:0] PRE_M = 8'he2;
   localparam logic [7:0] PRE_W = 8'he4;
   localparam logic [7:0] PRE_B = 8'he8;

   localparam logic [7:0] BLOCK_LAST    = 8'd191;
   localparam logic [7:0] STATUS_FRAMES = 8'd64;

   localparam logic [63:0] LEFT_CS_RESET  = 64'h0000_0000_0210_0004;
   localparam logic [63:0] RIGHT_CS_RESET = 64'h0000_0000_0220_0004;

   localparam logic [1:0] CSR_LEFT_CS  = 2'd0;
   localparam logic [1:0] CSR_RIGHT_CS = 2'd1;

   typedef struct packed {
      logic signed [31:0] left_sample;
      logic signed [31:0] right_sample;
   } spdif_req_type;

   typedef struct packed {
      logic [31:0] line_word;
      logic        last_of_frame;
   } spdif_rsp_type;

   typedef struct packed {
      logic [23:0] left_smp;
      logic [23:0] right_smp;
      logic [7:0]  left_pre;
      logic        left_cbit;
      logic        right_cbit;
   } spdif_desc_type;

endpackage

### hw/rtl/spdif_biphase_frame_encoder_top.sv
// top level of the biphase-mark stereo frame encoder
// Each accepted item is one stereo frame and yields four 32 half-bit line words, earliest
// half-bit in bit 31, the fourth flagged last_of_frame. The encoder produces one word per
// cycle while the output is not stalled; the queue can take a new item while the encoder
// is still on an earlier frame. Samples are saturated to signed 24 bits. A short queue of
// QUEUE_DEPTH frames decouples the input from the encoder, and a registered output stage
// holds a word while rsp_ready is low. The channel-status registers are written through
// csr_we, csr_index and csr_wdata (index 0 left, 1 right, others ignored); the user must
// write them only while the block is idle, as the block itself does not enforce it.
module spdif_biphase_frame_encoder_top import spdif_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  spdif_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output spdif_rsp_type rsp_data,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [63:0]   csr_wdata
);

   spdif_desc_type front_desc;
   spdif_desc_type back_desc;
   logic           accept;
   logic           back_valid;
   logic           back_pop;

   assign accept = req_valid & req_ready;

   spdif_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .accept    (accept),
      .desc      (front_desc)
   );

   spdif_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_desc),
      .pop_valid  (back_valid),
      .pop_ready  (back_pop),
      .pop_data   (back_desc)
   );

   spdif_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (back_valid),
      .desc_pop   (back_pop),
      .desc       (back_desc),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### hw/rtl/spdif_front.sv
// front end: status registers, frame counter, sample clamping and preamble choice
module spdif_front import spdif_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [63:0]    csr_wdata,
   input  spdif_req_type  req_data,
   input  logic           accept,
   output spdif_desc_type desc
);

   logic [63:0] lcs_ff,   lcs_in;
   logic [63:0] rcs_ff,   rcs_in;
   logic [7:0]  frame_ff, frame_in;
   logic        in_status;

   function automatic logic [23:0] clamp24(input logic signed [31:0] s);
      logic [23:0] r;
      if (!s[31] && (|s[30:23])) begin
         r = 24'h7fffff;
      end else if (s[31] && !(&s[30:23])) begin
         r = 24'h800000;
      end else begin
         r = s[23:0];
      end
      return r;
   endfunction

   always_comb begin
      lcs_in = lcs_ff;
      rcs_in = rcs_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LEFT_CS:  lcs_in = csr_wdata;
            CSR_RIGHT_CS: rcs_in = csr_wdata;
            default: ;
         endcase
      end
      frame_in = frame_ff;
      if (accept) begin
         frame_in = (frame_ff >= BLOCK_LAST) ? 8'd0 : frame_ff + 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcs_ff   <= LEFT_CS_RESET;
         rcs_ff   <= RIGHT_CS_RESET;
         frame_ff <= 8'd0;
      end else begin
         lcs_ff   <= lcs_in;
         rcs_ff   <= rcs_in;
         frame_ff <= frame_in;
      end
   end

   assign in_status = (frame_ff < STATUS_FRAMES);

   always_comb begin
      desc.left_smp   = clamp24(req_data.left_sample);
      desc.right_smp  = clamp24(req_data.right_sample);
      desc.left_pre   = (frame_ff == 8'd0) ? PRE_B : PRE_M;
      desc.left_cbit  = in_status & lcs_ff[frame_ff[5:0]];
      desc.right_cbit = in_status & rcs_ff[frame_ff[5:0]];
   end

endmodule

### hw/rtl/spdif_queue.sv
// small descriptor queue between front end and encoder
module spdif_queue import spdif_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push_valid,
   output logic           push_ready,
   input  spdif_desc_type push_data,
   output logic           pop_valid,
   input  logic           pop_ready,
   output spdif_desc_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   spdif_desc_type entry_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff,  count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/spdif_back.sv
// back end: biphase-mark coding of one 32 half-bit word per cycle unless stalled, output register
module spdif_back import spdif_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           desc_valid,
   output logic           desc_pop,
   input  spdif_desc_type desc,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output spdif_rsp_type  rsp_data
);

   logic [1:0]    word_ff,  word_in;
   logic          level_ff, level_in;
   logic          rsp_valid_ff, rsp_valid_in;
   spdif_rsp_type rsp_data_ff,  rsp_data_in;
   logic          advance;
   logic [23:0]   smp;
   logic          cbit;
   logic [7:0]    pre;
   logic [7:0]    sym;
   logic [27:0]   sub_payload;
   logic [31:0]   halves;
   logic          lv;
   logic          b;

   assign advance = desc_valid & (!rsp_valid_ff | rsp_ready);
   assign desc_pop = advance & (word_ff == 2'd3);

   always_comb begin
      smp         = word_ff[1] ? desc.right_smp  : desc.left_smp;
      cbit        = word_ff[1] ? desc.right_cbit : desc.left_cbit;
      pre         = word_ff[1] ? PRE_W           : desc.left_pre;
      sub_payload = {(^smp) ^ cbit, cbit, 1'b0, 1'b0, smp};
      sym         = level_ff ? ~pre : pre;
      halves      = '0;
      b           = 1'b0;
      if (!word_ff[0]) begin
         // preamble then sample bits 0 to 11
         halves[31:24] = sym;
         lv = sym[0];
         for (int i = 0; i < 12; i++) begin
            b = sub_payload[i];
            halves[23-2*i] = ~lv;
            lv = b ? lv : ~lv;
            halves[22-2*i] = lv;
         end
      end else begin
         // sample bits 12 to 23, validity, user, status, parity
         lv = level_ff;
         for (int i = 0; i < 16; i++) begin
            b = sub_payload[12+i];
            halves[31-2*i] = ~lv;
            lv = b ? lv : ~lv;
            halves[30-2*i] = lv;
         end
      end
   end

   always_comb begin
      word_in      = word_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         word_in                   = word_ff + 2'd1;
         level_in                  = lv;
         rsp_valid_in              = 1'b1;
         rsp_data_in.line_word     = halves;
         rsp_data_in.last_of_frame = (word_ff == 2'd3);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff      <= 2'd0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         word_ff      <= word_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### hw/rtl/spdif_checker.sv
// port-level checks for the frame encoder, bound to the top level
module spdif_checker import spdif_pkg::*; (
   input logic          clock,
   input logic          reset,
   input logic          rsp_valid,
   input logic          rsp_ready,
   input spdif_rsp_type rsp_data
);

   // a stalled word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");

   // nothing shown in the cycle after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("item shown straight after reset");

   // a word shown just after a frame's last word is taken is not itself a last word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_of_frame |=>
         !(rsp_valid && rsp_data.last_of_frame))
      else $error("two last words in a row");

   // last word is pure data: the line toggles at every symbol boundary
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last_of_frame |->
         (((rsp_data.line_word ^ (rsp_data.line_word >> 1)) & 32'h2aaa_aaaa) == 32'h2aaa_aaaa))
      else $error("missing symbol boundary transition");

endmodule

bind spdif_biphase_frame_encoder_top spdif_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
